// ----- rtl/core/owbte_pkg.sv -----
package owbte_pkg;

	// Parameter defaults
	localparam int MAX_BITS_DEF    = 64;
	localparam int COUNT_WIDTH_DEF = 10;

	// Field widths fixed by the interface
	localparam int ACT_W   = 2;
	localparam int CNT_W   = 7;
	localparam int DATA_W  = 64;
	localparam int REG_W   = 10;
	localparam int NUM_REG = 8;
	localparam int IDX_W   = 3;
	localparam int STAT_W  = 2;

	// Fixed timing in ticks
	localparam int LEAD_IN_US    = 100;
	localparam int WRITE_TAIL_US = 20;

	// Action codes on the input word
	localparam logic [ACT_W-1:0] ACT_TICK  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_RESET = 2'd1;
	localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;
	localparam logic [ACT_W-1:0] ACT_WRITE = 2'd3;

	// Operation codes, same encoding as the start actions
	localparam logic [ACT_W-1:0] OP_IDLE  = 2'd0;
	localparam logic [ACT_W-1:0] OP_RESET = 2'd1;
	localparam logic [ACT_W-1:0] OP_READ  = 2'd2;
	localparam logic [ACT_W-1:0] OP_WRITE = 2'd3;

	// Phase codes within an operation
	localparam logic [1:0] PH_START = 2'd0;
	localparam logic [1:0] PH_MID   = 2'd1;
	localparam logic [1:0] PH_END   = 2'd2;

	// Status codes
	localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_W-1:0] ST_LOW  = 2'd1;
	localparam logic [STAT_W-1:0] ST_BUSY = 2'd2;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_RESET_LOW  = 3'd0;
	localparam logic [IDX_W-1:0] REG_PRES_SMP   = 3'd1;
	localparam logic [IDX_W-1:0] REG_RESET_TAIL = 3'd2;
	localparam logic [IDX_W-1:0] REG_READ_LOW   = 3'd3;
	localparam logic [IDX_W-1:0] REG_READ_SMP   = 3'd4;
	localparam logic [IDX_W-1:0] REG_READ_TAIL  = 3'd5;
	localparam logic [IDX_W-1:0] REG_WRITE_LOW  = 3'd6;
	localparam logic [IDX_W-1:0] REG_WRITE_BIT  = 3'd7;

	typedef logic [REG_W-1:0] reg_val_t;

	// Register values after reset, by index
	localparam reg_val_t REG_RESET_VAL [NUM_REG] = '{
		10'd500, 10'd100, 10'd450, 10'd1, 10'd2, 10'd60, 10'd10, 10'd40
	};

endpackage

// ----- rtl/core/onewire_bit_timing_engine.sv -----
// The result word of an accepted input word is registered and offered in the next cycle.
// Throughput: one word per cycle; the result register is the only stage and
// takes a new word whenever it is empty or its word is taken in the same cycle.
// Reset (arst_n low, asynchronous): idle, line released, countdown and data
// cleared, timing registers at their default values, no result pending.
module onewire_bit_timing_engine #(
	parameter int MAX_BITS    = owbte_pkg::MAX_BITS_DEF,
	parameter int COUNT_WIDTH = owbte_pkg::COUNT_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cfg_wr_en,
	input  logic [owbte_pkg::IDX_W-1:0]     cfg_index,
	input  logic [owbte_pkg::REG_W-1:0]     cfg_data,
	// input channel
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [owbte_pkg::ACT_W-1:0]     action,
	input  logic [owbte_pkg::CNT_W-1:0]     bit_count,
	input  logic [owbte_pkg::DATA_W-1:0]    write_data,
	input  logic                            line_level,
	// output channel
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            drive_low,
	output logic                            busy_res,
	output logic                            done_res,
	output logic [owbte_pkg::STAT_W-1:0]    status,
	output logic                            presence,
	output logic [owbte_pkg::DATA_W-1:0]    read_data
);
	import owbte_pkg::*;

	localparam int BL_W  = $clog2(MAX_BITS + 1);
	localparam int CMP_W = (BL_W > CNT_W) ? BL_W : CNT_W;
	localparam int POS_W = BL_W + 1;

	// Timing registers
	reg_val_t regs_q [NUM_REG];

	// Sequencer state
	logic [ACT_W-1:0]       op_q, n_op;
	logic [1:0]             phase_q, n_phase;
	logic [COUNT_WIDTH-1:0] cnt_q, n_cnt;
	logic [BL_W-1:0]        bits_left_q, n_bits_left;
	logic [POS_W-1:0]       bit_pos_q, n_bit_pos;
	logic [DATA_W-1:0]      data_q, n_data;
	logic                   pres_q, n_pres;
	logic                   drive_q, n_drive;

	// Result register fields not held in the state
	logic                   out_valid_q;
	logic                   done_q, n_done;
	logic [STAT_W-1:0]      status_q, n_status;

	logic                   accept;
	logic                   fin;
	logic [CMP_W-1:0]       count_ext;
	logic [BL_W-1:0]        count_sat;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// Clip the requested bit count to the largest supported transfer
	always_comb begin
		count_ext = CMP_W'(bit_count);
		if (count_ext > CMP_W'(MAX_BITS)) begin
			count_sat = BL_W'(MAX_BITS);
		end else begin
			count_sat = BL_W'(count_ext);
		end
	end

	// Next state for one word
	always_comb begin
		n_op        = op_q;
		n_phase     = phase_q;
		n_cnt       = cnt_q;
		n_bits_left = bits_left_q;
		n_bit_pos   = bit_pos_q;
		n_data      = data_q;
		n_pres      = pres_q;
		n_drive     = drive_q;
		n_done      = 1'b0;
		n_status    = ST_OK;
		fin         = 1'b0;

		if (op_q != OP_IDLE) begin
			if (action != ACT_TICK) begin
				n_status = ST_BUSY;
			end
			if (cnt_q <= COUNT_WIDTH'(1)) begin
				n_cnt = '0;
				unique case (op_q)
					OP_RESET: begin
						if (phase_q == PH_START) begin
							n_drive = 1'b0;
							n_phase = PH_MID;
							n_cnt   = COUNT_WIDTH'(regs_q[REG_PRES_SMP]);
						end else if (phase_q == PH_MID) begin
							n_pres  = !line_level;
							n_phase = PH_END;
							n_cnt   = COUNT_WIDTH'(regs_q[REG_RESET_TAIL]);
						end else begin
							fin = 1'b1;
						end
					end
					OP_READ: begin
						if (phase_q == PH_START) begin
							if (bits_left_q == '0) begin
								fin = 1'b1;
							end else begin
								n_drive = 1'b1;
								n_phase = PH_MID;
								n_cnt   = COUNT_WIDTH'(regs_q[REG_READ_LOW]);
							end
						end else if (phase_q == PH_MID) begin
							n_drive = 1'b0;
							n_phase = PH_END;
							n_cnt   = COUNT_WIDTH'(regs_q[REG_READ_SMP]);
						end else begin
							n_bits_left = bits_left_q - BL_W'(1);
							if (32'(bit_pos_q) < DATA_W && line_level) begin
								n_data = data_q | (DATA_W'(1) << bit_pos_q);
							end
							n_bit_pos = bit_pos_q + POS_W'(1);
							n_phase   = PH_START;
							n_cnt     = COUNT_WIDTH'(regs_q[REG_READ_TAIL]);
						end
					end
					OP_WRITE: begin
						if (phase_q == PH_START) begin
							if (bits_left_q == '0) begin
								n_data = '0;
								fin    = 1'b1;
							end else begin
								n_drive = 1'b1;
								n_phase = PH_MID;
								n_cnt   = COUNT_WIDTH'(regs_q[REG_WRITE_LOW]);
							end
						end else if (phase_q == PH_MID) begin
							n_bits_left = bits_left_q - BL_W'(1);
							// a one bit releases the line early
							if (data_q[0]) begin
								n_drive = 1'b0;
							end
							n_data    = data_q >> 1;
							n_bit_pos = bit_pos_q + POS_W'(1);
							n_phase   = PH_END;
							n_cnt     = COUNT_WIDTH'(regs_q[REG_WRITE_BIT]);
						end else begin
							n_drive = 1'b0;
							n_phase = PH_START;
							n_cnt   = COUNT_WIDTH'(WRITE_TAIL_US);
						end
					end
					default: begin
						fin = 1'b1;
					end
				endcase
				if (fin) begin
					n_op    = OP_IDLE;
					n_phase = PH_START;
					n_drive = 1'b0;
					n_done  = 1'b1;
				end
			end else begin
				n_cnt = cnt_q - COUNT_WIDTH'(1);
			end
		end else if (action != ACT_TICK) begin
			if (!line_level) begin
				n_status = ST_LOW;
			end else begin
				n_op      = action;
				n_phase   = PH_START;
				n_bit_pos = '0;
				if (action == ACT_RESET) begin
					n_pres      = 1'b0;
					n_drive     = 1'b1;
					n_bits_left = '0;
					n_cnt       = COUNT_WIDTH'(regs_q[REG_RESET_LOW]);
				end else begin
					n_drive     = 1'b0;
					n_bits_left = count_sat;
					n_data      = (action == ACT_WRITE) ? write_data : '0;
					n_cnt       = COUNT_WIDTH'(LEAD_IN_US);
				end
			end
		end
	end

	// Timing register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REG; i++) begin
				regs_q[i] <= REG_RESET_VAL[i];
			end
		end else if (cfg_wr_en) begin
			regs_q[cfg_index] <= cfg_data;
		end
	end

	// Advance state and load the result word on accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q        <= OP_IDLE;
			phase_q     <= PH_START;
			cnt_q       <= '0;
			bits_left_q <= '0;
			bit_pos_q   <= '0;
			data_q      <= '0;
			pres_q      <= 1'b0;
			drive_q     <= 1'b0;
			done_q      <= 1'b0;
			status_q    <= ST_OK;
		end else if (accept) begin
			op_q        <= n_op;
			phase_q     <= n_phase;
			cnt_q       <= n_cnt;
			bits_left_q <= n_bits_left;
			bit_pos_q   <= n_bit_pos;
			data_q      <= n_data;
			pres_q      <= n_pres;
			drive_q     <= n_drive;
			done_q      <= n_done;
			status_q    <= n_status;
		end
	end

	// Hold the result word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign drive_low = drive_q;
	assign busy_res  = (op_q != OP_IDLE);
	assign done_res  = done_q;
	assign status    = status_q;
	assign presence  = pres_q;
	assign read_data = (op_q == OP_WRITE) ? '0 : data_q;

endmodule

// ----- rtl/core/owbte_checker.sv -----
module owbte_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic                            drive_low,
	input logic                            busy_res,
	input logic                            done_res,
	input logic [owbte_pkg::STAT_W-1:0]    status
);
	import owbte_pkg::*;

	// A stalled result word stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	// Every accepted word yields a result word next cycle
	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted word produced no result");

	// A finished operation leaves the sequencer idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res)
		else $error("done reported while still busy");

	// A start refused for a low line happens only when idle
	a_low_refuse_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_LOW |-> !busy_res)
		else $error("line-low refusal while busy");

	// The line is released whenever the sequencer is idle
	a_idle_release: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !busy_res |-> !drive_low)
		else $error("line driven low while idle");

endmodule

bind onewire_bit_timing_engine owbte_checker u_owbte_checker (.*);

// ----- sim/tb_onewire_bit_timing_engine.sv -----
module tb_onewire_bit_timing_engine;
	timeunit 1ns;
	timeprecision 1ps;
	import owbte_pkg::*;

	localparam int RUN_LIMIT    = 1_000_000;
	localparam int LONG_HOLD    = 300;
	localparam int RANDOM_WORDS = 200;
	localparam int MAX_REPORTS  = 50;

	// Line level behavior while ticking an operation out
	localparam int LINE_LOW    = 0;
	localparam int LINE_HIGH   = 1;
	localparam int LINE_RANDOM = 2;

	typedef struct packed {
		logic [ACT_W-1:0]  act;
		logic [CNT_W-1:0]  cnt;
		logic [DATA_W-1:0] data;
		logic              line;
	} bus_word_t;

	typedef struct packed {
		logic              drive;
		logic              busy;
		logic              done;
		logic [STAT_W-1:0] stat;
		logic              pres;
		logic [DATA_W-1:0] rdata;
	} bus_result_t;

	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              cfg_wr_en  = 1'b0;
	logic [IDX_W-1:0]  cfg_index  = '0;
	logic [REG_W-1:0]  cfg_data   = '0;
	logic              in_valid   = 1'b0;
	logic              in_ready;
	logic [ACT_W-1:0]  action     = ACT_TICK;
	logic [CNT_W-1:0]  bit_count  = '0;
	logic [DATA_W-1:0] write_data = '0;
	logic              line_level = 1'b1;
	logic              out_valid;
	logic              out_ready  = 1'b0;
	logic              drive_low;
	logic              busy_res;
	logic              done_res;
	logic [STAT_W-1:0] status;
	logic              presence;
	logic [DATA_W-1:0] read_data;

	onewire_bit_timing_engine i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.bit_count (bit_count),
		.write_data(write_data),
		.line_level(line_level),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.drive_low (drive_low),
		.busy_res  (busy_res),
		.done_res  (done_res),
		.status    (status),
		.presence  (presence),
		.read_data (read_data)
	);

	always #1 clk = ~clk;

	// Sequencer model state
	reg_val_t                   timing [NUM_REG];
	logic [ACT_W-1:0]           sq_op;
	logic [1:0]                 sq_phase;
	logic [COUNT_WIDTH_DEF-1:0] sq_count;
	logic [CNT_W-1:0]           sq_bits_left;
	logic [CNT_W-1:0]           sq_bit_pos;
	logic [DATA_W-1:0]          sq_shift;
	logic                       sq_pres;
	logic                       sq_drive;

	bus_result_t expected_results [$];
	int          err_cnt       = 0;
	int          words_sent    = 0;
	int          burst_left    = 0;
	int          cycles        = 0;
	int          hold_requests = 0;
	int          hold_served   = 0;
	int          hold_left     = 0;
	int          pat_mode      = 0;
	int          pat_left      = 0;

	task automatic model_reset();
		for (int i = 0; i < NUM_REG; i++)
			timing[i] = REG_RESET_VAL[i];
		sq_op        = OP_IDLE;
		sq_phase     = PH_START;
		sq_count     = '0;
		sq_bits_left = '0;
		sq_bit_pos   = '0;
		sq_shift     = '0;
		sq_pres      = 1'b0;
		sq_drive     = 1'b0;
	endtask

	function automatic void arm_countdown(input int unsigned ticks);
		sq_count = ticks[COUNT_WIDTH_DEF-1:0];
	endfunction

	// Take the bus action of the next phase; return 1 when the operation ends
	function automatic bit expire_phase(input logic line);
		expire_phase = 1'b0;
		case (sq_op)
			OP_RESET: begin
				if (sq_phase == PH_START) begin
					sq_drive = 1'b0;
					sq_phase = PH_MID;
					arm_countdown(timing[REG_PRES_SMP]);
				end else if (sq_phase == PH_MID) begin
					sq_pres  = ~line;
					sq_phase = PH_END;
					arm_countdown(timing[REG_RESET_TAIL]);
				end else begin
					expire_phase = 1'b1;
				end
			end
			OP_READ: begin
				if (sq_phase == PH_START) begin
					if (sq_bits_left == 0) begin
						expire_phase = 1'b1;
					end else begin
						sq_drive = 1'b1;
						sq_phase = PH_MID;
						arm_countdown(timing[REG_READ_LOW]);
					end
				end else if (sq_phase == PH_MID) begin
					sq_drive = 1'b0;
					sq_phase = PH_END;
					arm_countdown(timing[REG_READ_SMP]);
				end else begin
					sq_bits_left = sq_bits_left - 1'b1;
					if (sq_bit_pos < DATA_W && line)
						sq_shift[sq_bit_pos[5:0]] = 1'b1;
					sq_bit_pos = sq_bit_pos + 1'b1;
					sq_phase   = PH_START;
					arm_countdown(timing[REG_READ_TAIL]);
				end
			end
			OP_WRITE: begin
				if (sq_phase == PH_START) begin
					if (sq_bits_left == 0) begin
						sq_shift     = '0;
						expire_phase = 1'b1;
					end else begin
						sq_drive = 1'b1;
						sq_phase = PH_MID;
						arm_countdown(timing[REG_WRITE_LOW]);
					end
				end else if (sq_phase == PH_MID) begin
					sq_bits_left = sq_bits_left - 1'b1;
					if (sq_shift[0])
						sq_drive = 1'b0;
					sq_shift   = sq_shift >> 1;
					sq_bit_pos = sq_bit_pos + 1'b1;
					sq_phase   = PH_END;
					arm_countdown(timing[REG_WRITE_BIT]);
				end else begin
					sq_drive = 1'b0;
					sq_phase = PH_START;
					arm_countdown(WRITE_TAIL_US);
				end
			end
			default: begin
				expire_phase = 1'b1;
			end
		endcase
	endfunction

	// Advance the sequencer by one word and return the bus state it leaves
	function automatic bus_result_t step_sequencer(input bus_word_t w);
		bus_result_t       r;
		logic [STAT_W-1:0] st;
		logic              fin;
		logic [CNT_W-1:0]  n;
		st  = ST_OK;
		fin = 1'b0;
		if (sq_op != OP_IDLE) begin
			if (w.act != ACT_TICK)
				st = ST_BUSY;
			if (sq_count <= 1) begin
				sq_count = '0;
				if (expire_phase(w.line)) begin
					sq_op    = OP_IDLE;
					sq_phase = PH_START;
					sq_drive = 1'b0;
					fin      = 1'b1;
				end
			end else begin
				sq_count = sq_count - 1'b1;
			end
		end else if (w.act != ACT_TICK) begin
			if (!w.line) begin
				st = ST_LOW;
			end else begin
				n          = (w.cnt > MAX_BITS_DEF) ? CNT_W'(MAX_BITS_DEF) : w.cnt;
				sq_op      = w.act;
				sq_phase   = PH_START;
				sq_bit_pos = '0;
				if (w.act == ACT_RESET) begin
					sq_pres      = 1'b0;
					sq_drive     = 1'b1;
					sq_bits_left = '0;
					arm_countdown(timing[REG_RESET_LOW]);
				end else begin
					sq_drive     = 1'b0;
					sq_bits_left = n;
					sq_shift     = (w.act == ACT_WRITE) ? w.data : '0;
					arm_countdown(LEAD_IN_US);
				end
			end
		end
		r.drive = sq_drive;
		r.busy  = (sq_op != OP_IDLE);
		r.done  = fin;
		r.stat  = st;
		r.pres  = sq_pres;
		r.rdata = (sq_op == OP_WRITE) ? '0 : sq_shift;
		return r;
	endfunction

	function automatic bus_word_t make_word(input logic [ACT_W-1:0] act,
		input logic [CNT_W-1:0] cnt, input logic [DATA_W-1:0] data, input logic line);
		bus_word_t w;
		w.act  = act;
		w.cnt  = cnt;
		w.data = data;
		w.line = line;
		return w;
	endfunction

	// Offer one word in bursts with random gaps; predict on acceptance
	task automatic send_word(input bus_word_t w);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid   <= 1'b1;
		action     <= w.act;
		bit_count  <= w.cnt;
		write_data <= w.data;
		line_level <= w.line;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		expected_results.push_back(step_sequencer(w));
		words_sent++;
	endtask

	// Drop valid and wait for every pending result word
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic set_timing(input logic [IDX_W-1:0] idx, input reg_val_t val);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		timing[idx] = val;
	endtask

	task automatic set_all_timing(input reg_val_t rst_low, input reg_val_t pres_smp,
		input reg_val_t rst_tail, input reg_val_t rd_low, input reg_val_t rd_smp,
		input reg_val_t rd_tail, input reg_val_t wr_low, input reg_val_t wr_bit);
		set_timing(REG_RESET_LOW, rst_low);
		set_timing(REG_PRES_SMP, pres_smp);
		set_timing(REG_RESET_TAIL, rst_tail);
		set_timing(REG_READ_LOW, rd_low);
		set_timing(REG_READ_SMP, rd_smp);
		set_timing(REG_READ_TAIL, rd_tail);
		set_timing(REG_WRITE_LOW, wr_low);
		set_timing(REG_WRITE_BIT, wr_bit);
	endtask

	task automatic start_op(input logic [ACT_W-1:0] act, input logic [CNT_W-1:0] cnt,
		input logic [DATA_W-1:0] data);
		send_word(make_word(act, cnt, data, 1'b1));
	endtask

	// Tick until the sequencer is idle, with some refused starts mixed in
	task automatic run_out(input int line_mode, input int busy_pct);
		bus_word_t w;
		while (sq_op != OP_IDLE) begin
			w = make_word(ACT_TICK, CNT_W'($urandom_range(0, 127)), {$urandom, $urandom}, 1'b1);
			case (line_mode)
				LINE_LOW:  w.line = 1'b0;
				LINE_HIGH: w.line = 1'b1;
				default:   w.line = 1'($urandom_range(0, 1));
			endcase
			if ($urandom_range(0, 99) < busy_pct)
				w.act = ACT_W'($urandom_range(1, 3));
			send_word(w);
		end
	endtask

	function automatic reg_val_t pick_timing();
		if ($urandom_range(0, 9) == 0)
			return REG_W'($urandom_range(8, 60));
		return REG_W'($urandom_range(0, 3));
	endfunction

	function automatic logic [CNT_W-1:0] pick_count();
		if ($urandom_range(0, 9) < 8)
			return CNT_W'($urandom_range(0, 8));
		return CNT_W'($urandom_range(0, 16));
	endfunction

	// Idle ticks and starts refused because the line is low
	task automatic test_idle_words();
		send_word(make_word(ACT_TICK, '0, '0, 1'b1));
		send_word(make_word(ACT_TICK, '1, '1, 1'b0));
		send_word(make_word(ACT_RESET, '1, '1, 1'b0));
		send_word(make_word(ACT_READ, CNT_W'(MAX_BITS_DEF), '0, 1'b0));
		send_word(make_word(ACT_WRITE, '1, '1, 1'b0));
		send_word(make_word(ACT_TICK, '0, '0, 1'b0));
	endtask

	// Reset pulses with short timing and both answers, a read between them
	task automatic test_reset_presence();
		set_all_timing(10'd3, 10'd2, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1);
		start_op(ACT_RESET, '0, '0);
		run_out(LINE_LOW, 3);
		start_op(ACT_RESET, '1, '1);
		run_out(LINE_HIGH, 0);
		start_op(ACT_READ, 7'd4, '0);
		run_out(LINE_RANDOM, 0);
		start_op(ACT_RESET, '0, '0);
		run_out(LINE_RANDOM, 10);
	endtask

	// Zero counts and a count beyond the limit
	task automatic test_bit_counts();
		start_op(ACT_READ, '0, '1);
		run_out(LINE_RANDOM, 0);
		start_op(ACT_WRITE, '0, '1);
		run_out(LINE_RANDOM, 0);
		start_op(ACT_READ, '1, '0);
		run_out(LINE_RANDOM, 5);
		start_op(ACT_WRITE, 7'd3, 64'h5555_AAAA_0F0F_F0F5);
		run_out(LINE_RANDOM, 0);
	endtask

	// Zero in every timing register
	task automatic test_timing_extremes();
		set_all_timing('0, '0, '0, '0, '0, '0, '0, '0);
		start_op(ACT_RESET, '0, '0);
		run_out(LINE_LOW, 0);
		start_op(ACT_READ, 7'd3, '0);
		run_out(LINE_RANDOM, 5);
		start_op(ACT_WRITE, 7'd1, {$urandom, $urandom});
		run_out(LINE_RANDOM, 5);
	endtask

	// Hold the result side off while words keep coming
	task automatic test_backpressure();
		set_all_timing(10'd2, 10'd1, 10'd2, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1);
		hold_requests++;
		start_op(ACT_RESET, '0, '0);
		run_out(LINE_RANDOM, 5);
	endtask

	// Random operations with random timing, plus noise and refused starts
	task automatic test_random_ops();
		int first;
		int ops;
		first = words_sent;
		ops   = 0;
		while (words_sent - first < RANDOM_WORDS) begin
			if (ops % 3 == 0)
				set_all_timing(pick_timing(), pick_timing(), pick_timing(), pick_timing(),
					pick_timing(), pick_timing(), pick_timing(), pick_timing());
			ops++;
			case ($urandom_range(0, 9))
				0: begin
					repeat ($urandom_range(1, 4))
						send_word(make_word(ACT_TICK, CNT_W'($urandom_range(0, 127)),
							{$urandom, $urandom}, 1'($urandom_range(0, 1))));
				end
				1: begin
					send_word(make_word(ACT_W'($urandom_range(1, 3)), pick_count(),
						{$urandom, $urandom}, 1'b0));
				end
				default: begin
					start_op(ACT_W'($urandom_range(1, 3)), pick_count(), {$urandom, $urandom});
					run_out(LINE_RANDOM, 6);
				end
			endcase
		end
	endtask

	// Result side: long hold-off on request, else a changing stall pattern
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_requests) begin
			hold_served <= hold_served + 1;
			hold_left   <= LONG_HOLD;
			out_ready   <= 1'b0;
		end else begin
			if (pat_left == 0) begin
				pat_mode <= $urandom_range(0, 3);
				pat_left <= $urandom_range(8, 64);
			end else begin
				pat_left <= pat_left - 1;
			end
			case (pat_mode)
				0:       out_ready <= 1'b1;
				1:       out_ready <= ($urandom_range(0, 3) != 0);
				2:       out_ready <= 1'($urandom_range(0, 1));
				default: out_ready <= ($urandom_range(0, 4) == 0);
			endcase
		end
	end

	function automatic void check_field(input string name, input logic [DATA_W-1:0] exp_v,
		input logic [DATA_W-1:0] got_v);
		if (exp_v !== got_v) begin
			err_cnt++;
			if (err_cnt <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
		end
	endfunction

	// Compare each accepted result word with the oldest prediction
	always @(posedge clk) begin : check_results
		bus_result_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				err_cnt++;
				if (err_cnt <= MAX_REPORTS)
					$display("%0t: result word with none expected, expected none, actual %b %b %b %h %b %h",
						$time, drive_low, busy_res, done_res, status, presence, read_data);
			end else begin
				exp_r = expected_results.pop_front();
				check_field("drive_low", DATA_W'(exp_r.drive), DATA_W'(drive_low));
				check_field("busy_res", DATA_W'(exp_r.busy), DATA_W'(busy_res));
				check_field("done_res", DATA_W'(exp_r.done), DATA_W'(done_res));
				check_field("status", DATA_W'(exp_r.stat), DATA_W'(status));
				check_field("presence", DATA_W'(exp_r.pres), DATA_W'(presence));
				check_field("read_data", exp_r.rdata, read_data);
			end
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= RUN_LIMIT) begin
			$display("tb_onewire_bit_timing_engine: done, errors");
			$finish;
		end
	end

	initial begin
		model_reset();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_words();
		test_reset_presence();
		test_bit_counts();
		test_timing_extremes();
		test_backpressure();
		test_random_ops();
		wait_drained();
		repeat (4) @(posedge clk);
		if (err_cnt == 0 && expected_results.size() == 0)
			$display("tb_onewire_bit_timing_engine: done, clean");
		else
			$display("tb_onewire_bit_timing_engine: done, errors");
		$finish;
	end

endmodule
